[rtl/core/mstw_pkg.sv]
// Package with shared constants and command codes for the spanning tree weight unit.
`timescale 1ns / 1ps

package mstw_pkg;

    localparam int MSTW_MAX_NODES = 64;
    localparam int NODE_FIELD_W   = 6;
    localparam int WEIGHT_W       = 16;
    localparam int TOTAL_W        = 32;
    localparam int IN_DATA_W      = 32;
    localparam int OUT_DATA_W     = 32;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

endpackage

[rtl/core/minimum_spanning_tree_weight_unit.sv]
// Minimum spanning tree weight unit: edge store, Prim sequencer and result register.
// Add edge: a valid add is busy in ST_ADD_WR1 and ST_ADD_WR2 (read, write both directions).
// Clear graph: a sweep over all MAX_NODES*MAX_NODES entries of the edge memory.
// Run: all MAX_NODES vertex entries are initialised, then each tree vertex is marked and
// its edge row walked by the single read port; ST_FINISH then registers the total.
// After reset all MAX_NODES*MAX_NODES edge memory entries are swept before input is taken.
`timescale 1ns / 1ps

module minimum_spanning_tree_weight_unit
    import mstw_pkg::*;
#(
    parameter int MAX_NODES = MSTW_MAX_NODES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // cmd[1:0], node_a[7:2], node_b[13:8], weight[29:14]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // total_weight[31:0]
);

    localparam int DEPTH   = MAX_NODES * MAX_NODES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int EDGE_W  = WEIGHT_W + 1;
    localparam int VERT_W  = WEIGHT_W + 2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR1,
        ST_ADD_WR2,
        ST_INIT,
        ST_MARK,
        ST_RELAX,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     ab_addr_reg;
    logic [ADDR_W-1:0]     ba_addr_reg;
    logic [WEIGHT_W-1:0]   w_reg;
    logic                  upd_reg;
    logic [NODE_W-1:0]     start_reg;
    logic [NODE_W-1:0]     vcnt_reg;
    logic                  issuing_reg;
    logic                  p_valid_reg;
    logic [NODE_W-1:0]     pick_reg;
    logic [WEIGHT_W-1:0]   pick_w_reg;
    logic [ADDR_W-1:0]     pick_base_reg;
    logic                  cand_found_reg;
    logic [NODE_W-1:0]     cand_idx_reg;
    logic [WEIGHT_W-1:0]   cand_w_reg;
    logic [NODE_W-1:0]     p_u_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic                  m_tvalid_reg;
    logic [TOTAL_W-1:0]    m_tdata_reg;

    logic [1:0]            in_cmd;
    logic [NODE_FIELD_W-1:0] in_a;
    logic [NODE_FIELD_W-1:0] in_b;
    logic [WEIGHT_W-1:0]   in_w;
    logic                  a_ok;
    logic                  b_ok;
    logic [ADDR_W-1:0]     in_ab_addr;
    logic [ADDR_W-1:0]     in_ba_addr;
    logic                  accept;

    logic                  edge_we;
    logic [ADDR_W-1:0]     edge_waddr;
    logic [EDGE_W-1:0]     edge_wdata;
    logic [ADDR_W-1:0]     edge_raddr;
    logic [EDGE_W-1:0]     edge_rdata;
    logic                  vert_we;
    logic [NODE_W-1:0]     vert_waddr;
    logic [VERT_W-1:0]     vert_wdata;
    logic [NODE_W-1:0]     vert_raddr;
    logic [VERT_W-1:0]     vert_rdata;

    logic                  add_upd;
    logic                  relax_upd;
    logic                  new_unreached;
    logic [WEIGHT_W-1:0]   new_w;
    logic                  cand_take;
    logic                  vcnt_last;

    assign in_cmd = s_tdata[1:0];
    assign in_a   = s_tdata[7:2];
    assign in_b   = s_tdata[13:8];
    assign in_w   = s_tdata[29:14];

    assign a_ok       = int'(in_a) < MAX_NODES;
    assign b_ok       = int'(in_b) < MAX_NODES;
    assign in_ab_addr = ADDR_W'(NODE_W'(in_a)) * ADDR_W'(MAX_NODES) + ADDR_W'(NODE_W'(in_b));
    assign in_ba_addr = ADDR_W'(NODE_W'(in_b)) * ADDR_W'(MAX_NODES) + ADDR_W'(NODE_W'(in_a));

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign vcnt_last = (vcnt_reg == NODE_W'(MAX_NODES - 1));

    assign add_upd = edge_rdata[WEIGHT_W]
                     || ($signed(w_reg) < $signed(edge_rdata[WEIGHT_W-1:0]));

    // A vertex already in the tree keeps its entry; a reached one takes a lighter edge.
    assign relax_upd = p_valid_reg && !vert_rdata[WEIGHT_W+1] && !edge_rdata[WEIGHT_W]
                       && (vert_rdata[WEIGHT_W]
                           || ($signed(edge_rdata[WEIGHT_W-1:0])
                               < $signed(vert_rdata[WEIGHT_W-1:0])));
    assign new_unreached = vert_rdata[WEIGHT_W] && !relax_upd;
    assign new_w = relax_upd ? edge_rdata[WEIGHT_W-1:0] : vert_rdata[WEIGHT_W-1:0];
    assign cand_take = p_valid_reg && !vert_rdata[WEIGHT_W+1] && !new_unreached
                       && (!cand_found_reg || ($signed(new_w) < $signed(cand_w_reg)));

    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = clr_addr_reg;
        edge_wdata = {1'b1, {WEIGHT_W{1'b0}}};
        edge_raddr = in_ab_addr;
        vert_we    = 1'b0;
        vert_waddr = vcnt_reg;
        vert_wdata = {2'b01, {WEIGHT_W{1'b0}}};
        vert_raddr = vcnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                edge_we = 1'b1;
            end
            ST_ADD_WR1:
            begin
                edge_we    = add_upd;
                edge_waddr = ab_addr_reg;
                edge_wdata = {1'b0, w_reg};
            end
            ST_ADD_WR2:
            begin
                edge_we    = upd_reg;
                edge_waddr = ba_addr_reg;
                edge_wdata = {1'b0, w_reg};
            end
            ST_INIT:
            begin
                vert_we = 1'b1;
                if (vcnt_reg == start_reg)
                begin
                    vert_wdata = {2'b00, {WEIGHT_W{1'b0}}};
                end
            end
            ST_MARK:
            begin
                vert_we    = 1'b1;
                vert_waddr = pick_reg;
                vert_wdata = {2'b10, pick_w_reg};
            end
            ST_RELAX:
            begin
                edge_raddr = pick_base_reg + ADDR_W'(vcnt_reg);
                vert_we    = relax_upd;
                vert_waddr = p_u_reg;
                vert_wdata = {2'b00, edge_rdata[WEIGHT_W-1:0]};
            end
            default:
            begin
                edge_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            vcnt_reg       <= '0;
            issuing_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
            cand_found_reg <= 1'b0;
            upd_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ab_addr_reg <= in_ab_addr;
                        ba_addr_reg <= in_ba_addr;
                        w_reg       <= in_w;
                        start_reg   <= NODE_W'(in_a);
                        vcnt_reg    <= '0;
                        case (cmd_t'(in_cmd))
                            CMD_ADD:
                            begin
                                if (a_ok && b_ok && (in_a != in_b))
                                begin
                                    state_reg <= ST_ADD_WR1;
                                end
                            end
                            CMD_RUN:
                            begin
                                total_reg <= '0;
                                state_reg <= a_ok ? ST_INIT : ST_FINISH;
                            end
                            CMD_CLEAR:
                            begin
                                state_reg <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_ADD_WR1:
                begin
                    upd_reg   <= add_upd;
                    state_reg <= ST_ADD_WR2;
                end
                ST_ADD_WR2:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_INIT:
                begin
                    vcnt_reg <= vcnt_reg + NODE_W'(1);
                    if (vcnt_last)
                    begin
                        pick_reg   <= start_reg;
                        pick_w_reg <= '0;
                        state_reg  <= ST_MARK;
                    end
                end
                ST_MARK:
                begin
                    total_reg      <= total_reg + TOTAL_W'($signed(pick_w_reg));
                    pick_base_reg  <= ADDR_W'(pick_reg) * ADDR_W'(MAX_NODES);
                    vcnt_reg       <= '0;
                    issuing_reg    <= 1'b1;
                    p_valid_reg    <= 1'b0;
                    cand_found_reg <= 1'b0;
                    state_reg      <= ST_RELAX;
                end
                ST_RELAX:
                begin
                    p_valid_reg <= issuing_reg;
                    p_u_reg     <= vcnt_reg;
                    if (issuing_reg)
                    begin
                        vcnt_reg <= vcnt_reg + NODE_W'(1);
                        if (vcnt_last)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    if (cand_take)
                    begin
                        cand_found_reg <= 1'b1;
                        cand_idx_reg   <= p_u_reg;
                        cand_w_reg     <= new_w;
                    end
                    if (!issuing_reg && !p_valid_reg)
                    begin
                        if (cand_found_reg)
                        begin
                            pick_reg   <= cand_idx_reg;
                            pick_w_reg <= cand_w_reg;
                            state_reg  <= ST_MARK;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= total_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    mstw_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    mstw_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_NODES)
    ) u_vert_ram (
        .clk   (clk),
        .we    (vert_we),
        .waddr (vert_waddr),
        .wdata (vert_wdata),
        .raddr (vert_raddr),
        .rdata (vert_rdata)
    );

endmodule

[rtl/core/mstw_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mstw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the minimum spanning tree weight unit.
`timescale 1ns / 1ps

module tb_top;

    import mstw_pkg::*;

    localparam int NODES         = MSTW_MAX_NODES;
    localparam int RANDOM_ITEMS  = 700;
    localparam int IDLE_LIMIT    = 40000;
    localparam int SETTLE_CYCLES = 5000;
    localparam int EXP_DEPTH     = 256;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // cmd[1:0], node_a[7:2], node_b[13:8], weight[29:14]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // total_weight[31:0]

    bit                    edge_present [NODES][NODES];
    logic signed [15:0]    edge_weight  [NODES][NODES];
    logic [31:0]           expected_totals [EXP_DEPTH];
    int                    exp_wr;
    int                    exp_rd;

    bit steady_flow;
    int failures;
    int totals_checked;
    int adds_sent;
    int runs_sent;
    int clears_sent;
    int ignored_sent;
    int items_sent;
    int idle_cycles;

    minimum_spanning_tree_weight_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap(input int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, long_max);
    endfunction

    function automatic void clear_edges();
        int i;
        int j;
        for (i = 0; i < NODES; i++)
        begin
            for (j = 0; j < NODES; j++)
            begin
                edge_present[i][j] = 1'b0;
                edge_weight[i][j]  = '0;
            end
        end
    endfunction

    function automatic void keep_lighter_edge(input int from, input int to,
                                              input logic signed [15:0] w);
        if (!edge_present[from][to] || w < edge_weight[from][to])
        begin
            edge_present[from][to] = 1'b1;
            edge_weight[from][to]  = w;
        end
    endfunction

    function automatic logic [31:0] tree_weight_from(input logic [5:0] start);
        bit                 in_tree [NODES];
        bit                 reached [NODES];
        logic signed [15:0] link    [NODES];
        logic signed [15:0] pick_w;
        int                 total;
        int                 pick;
        int                 step;
        int                 u;
        total = 0;
        for (u = 0; u < NODES; u++)
        begin
            in_tree[u] = 1'b0;
            reached[u] = 1'b0;
            link[u]    = '0;
        end
        if (start >= NODES)
            return '0;
        reached[start] = 1'b1;
        for (step = 0; step < NODES; step++)
        begin
            pick   = -1;
            pick_w = '0;
            for (u = 0; u < NODES; u++)
            begin
                if (reached[u] && !in_tree[u] && (pick < 0 || link[u] < pick_w))
                begin
                    pick   = u;
                    pick_w = link[u];
                end
            end
            if (pick < 0)
                break;
            in_tree[pick] = 1'b1;
            total += pick_w;
            for (u = 0; u < NODES; u++)
            begin
                if (!in_tree[u] && edge_present[pick][u] &&
                    (!reached[u] || edge_weight[pick][u] < link[u]))
                begin
                    reached[u] = 1'b1;
                    link[u]    = edge_weight[pick][u];
                end
            end
        end
        return total;
    endfunction

    function automatic void update_graph(input cmd_t c, input logic [5:0] a,
                                         input logic [5:0] b,
                                         input logic signed [15:0] w);
        items_sent++;
        case (c)
            CMD_ADD:
            begin
                adds_sent++;
                if (a != b && a < NODES && b < NODES)
                begin
                    keep_lighter_edge(a, b, w);
                    keep_lighter_edge(b, a, w);
                end
                else
                    ignored_sent++;
            end
            CMD_RUN:
            begin
                runs_sent++;
                expected_totals[exp_wr % EXP_DEPTH] = tree_weight_from(a);
                exp_wr++;
            end
            CMD_CLEAR:
            begin
                clears_sent++;
                clear_edges();
            end
            default:
                ignored_sent++;
        endcase
    endfunction

    task automatic send_item(input cmd_t c, input logic [5:0] a, input logic [5:0] b,
                             input logic signed [15:0] w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w, b, a, c};
        do
            @(posedge clk);
        while (!s_tready);
        update_graph(c, a, b, w);
        gap = steady_flow ? 0 : pick_gap(60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        wait (exp_rd == exp_wr);
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_weight();
        int v;
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3, 4:
            begin
                v = $urandom_range(0, 16);
                return 16'(v - 8);
            end
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_graph_sequence();
        int lo;
        int span;
        int n_edges;
        int n_runs;
        int k;
        int r;
        logic [5:0] a;
        logic [5:0] b;
        span    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 7);
        lo      = $urandom_range(0, 63 - span);
        n_edges = $urandom_range(1, (span < 10) ? 3 * span : 40);
        n_runs  = $urandom_range(1, 2);
        if ($urandom_range(0, 4) != 0)
            send_item(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      random_weight());
        for (k = 0; k < n_edges; k++)
        begin
            r = $urandom_range(0, 99);
            a = 6'(lo + $urandom_range(0, span));
            b = 6'(lo + $urandom_range(0, span));
            if (r < 6)
                send_item(CMD_NONE, a, b, random_weight());
            else if (r < 12)
                send_item(CMD_ADD, a, a, random_weight());
            else
                send_item(CMD_ADD, a, b, random_weight());
        end
        for (k = 0; k < n_runs; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                a = 6'($urandom_range(0, 63));
            else
                a = 6'(lo + $urandom_range(0, span));
            send_item(CMD_RUN, a, 6'($urandom_range(0, 63)), random_weight());
        end
    endtask

    task automatic test_empty_graph();
        send_item(CMD_RUN, 6'd0, 6'd63, 16'sh7fff);
        send_item(CMD_RUN, 6'd63, 6'd0, 16'sh8000);
    endtask

    task automatic test_edge_extremes();
        send_item(CMD_ADD, 6'd0, 6'd63, 16'sh8000);
        send_item(CMD_ADD, 6'd63, 6'd0, 16'sh7fff);
        send_item(CMD_ADD, 6'd5, 6'd5, -16'sd100);
        send_item(CMD_ADD, 6'd1, 6'd62, 16'sh7fff);
        send_item(CMD_ADD, 6'd62, 6'd1, -16'sd1);
        send_item(CMD_ADD, 6'd0, 6'd1, 16'sd0);
        send_item(CMD_NONE, 6'd63, 6'd63, -16'sd1);
        send_item(CMD_RUN, 6'd0, 6'd0, 16'sd0);
        send_item(CMD_RUN, 6'd62, 6'd0, 16'sd0);
        send_item(CMD_ADD, 6'd2, 6'd3, -16'sd5);
        send_item(CMD_RUN, 6'd3, 6'd0, 16'sd0);
        send_item(CMD_RUN, 6'd10, 6'd0, 16'sd0);
    endtask

    task automatic test_clear();
        send_item(CMD_CLEAR, 6'd63, 6'd63, -16'sd1);
        send_item(CMD_RUN, 6'd0, 6'd0, 16'sd0);
        send_item(CMD_ADD, 6'd0, 6'd1, 16'sd7);
        send_item(CMD_RUN, 6'd1, 6'd0, 16'sd0);
        send_item(CMD_CLEAR, 6'd0, 6'd0, 16'sd0);
    endtask

    task automatic test_random_graphs();
        int first;
        int seq;
        first = items_sent;
        seq   = 0;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            random_graph_sequence();
            seq++;
            if (seq % 8 == 0)
                wait_for_results();
        end
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        random_graph_sequence();
        random_graph_sequence();
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        int n;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (steady_flow)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                n = pick_gap(200);
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // Each accepted result transaction is matched against the oldest predicted total.
    initial
    begin
        logic [31:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (exp_rd == exp_wr)
                begin
                    $error("total_weight: expected nothing, actual %0d", $signed(m_tdata));
                    failures++;
                end
                else
                begin
                    want = expected_totals[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    totals_checked++;
                    if (m_tdata !== want)
                    begin
                        $error("total_weight: expected %0d, actual %0d",
                               $signed(want), $signed(m_tdata));
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        steady_flow = 1'b0;
        clear_edges();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_graph();
        test_edge_extremes();
        test_clear();
        test_random_graphs();
        test_back_to_back();

        wait_for_results();
        steady_flow = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d edge adds, %0d runs and %0d clears; %0d had no effect.",
                 items_sent, adds_sent, runs_sent, clears_sent, ignored_sent);
        $display("Compared %0d tree totals with the predicted values.", totals_checked);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[minimum_spanning_tree_weight_unit.f]
rtl/core/mstw_pkg.sv
rtl/core/mstw_ram.sv
rtl/core/minimum_spanning_tree_weight_unit.sv
tb/sv/tb_top.sv
